[design/bbwm_pkg.sv]
// ----------------------------------------------------------------------------
// Box blur window mean: shared package
// Field widths, register addresses, reset values and item codes.
// ----------------------------------------------------------------------------
package bbwm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS_DEF = 15;

  localparam int PIXEL_W = 8;
  localparam int DIM_W   = 11;
  localparam int RAD_W   = 4;
  localparam int PADDR_W = 4;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd1024;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 4'd15;

  localparam logic [PADDR_W-1:0] REG_WIDTH  = 4'd0;
  localparam logic [PADDR_W-1:0] REG_HEIGHT = 4'd4;
  localparam logic [PADDR_W-1:0] REG_RADIUS = 4'd8;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

endpackage

[design/box_blur_window_mean_top.sv]
// ----------------------------------------------------------------------------
// Box blur window mean: top level
// Mean over a square window of in-image pixels, streamed in raster order.
// ----------------------------------------------------------------------------
// Usage: pixels enter on the in channel (in_valid/in_stall, mode, pixel) in
// raster order, mode 0. Once input row y+radius+1 arrives, each pixel also
// produces the output for row y. After the frame's last pixel, flush items
// (mode 1) drain the remaining rows, one output each; frame_last marks the
// final output, after which a new frame starts. Results leave on the out
// channel (out_valid/out_stall, blurred, frame_last) from an output register.
// One item is handled at a time. An item that only stores a pixel does not
// stall the input. An item that produces an output reads the whole window
// from the line store, one pixel per cycle through its single read port,
// then divides by the pixel count one bit per cycle. in_stall stays high
// while an output is being formed or while a result waits in the output
// register; a stalled receiver holds the result and the block takes
// nothing new.
// Reset clears the position counters and restores the register defaults;
// the line store needs no clearing. The frame width, height and radius are
// written over the APB port at byte addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module box_blur_window_mean_top #(
  parameter int MAX_WIDTH  = bbwm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbwm_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = bbwm_pkg::MAX_RADIUS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bbwm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic [bbwm_pkg::PIXEL_W-1:0] pixel,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bbwm_pkg::PIXEL_W-1:0] blurred,
  output logic                         frame_last
);
  import bbwm_pkg::*;

  localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int MEM_DEPTH = LINE_ROWS * MAX_WIDTH;
  localparam int MADDR_W   = $clog2(MEM_DEPTH);
  localparam int SLOT_W    = $clog2(LINE_ROWS);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int INROW_W   = $clog2(MAX_HEIGHT + 1);
  localparam int EW_W      = $clog2(MAX_WIDTH + 1);
  localparam int EH_W      = $clog2(MAX_HEIGHT + 1);
  localparam int ER_W      = $clog2(MAX_RADIUS + 1);
  localparam int Y_W       = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int X_W       = $clog2(MAX_WIDTH + MAX_RADIUS + 2);
  localparam int WIN       = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W     = $clog2(WIN + 1);
  localparam int SUM_W     = PIXEL_W + CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  // Configuration registers.
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [RAD_W-1:0] radius;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      radius       <= RADIUS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        REG_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        REG_RADIUS: radius       <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      REG_RADIUS: prdata = 32'(radius);
      default:    prdata = '0;
    endcase
  end

  // Effective (clamped) geometry.
  logic [EW_W-1:0] ew;
  logic [EH_W-1:0] eh;
  logic [ER_W-1:0] er;

  always_comb begin
    if (frame_width == '0) ew = EW_W'(1);
    else if (32'(frame_width) > MAX_WIDTH) ew = EW_W'(MAX_WIDTH);
    else ew = EW_W'(frame_width);
    if (frame_height == '0) eh = EH_W'(1);
    else if (32'(frame_height) > MAX_HEIGHT) eh = EH_W'(MAX_HEIGHT);
    else eh = EH_W'(frame_height);
    if (32'(radius) > MAX_RADIUS) er = ER_W'(MAX_RADIUS);
    else er = ER_W'(radius);
  end

  // Position state.
  logic [2:0]         state;
  logic [COL_W-1:0]   in_column;
  logic [INROW_W-1:0] in_row;
  logic [SLOT_W-1:0]  in_slot;
  logic [COL_W-1:0]   out_column;
  logic [ROW_W-1:0]   out_row;
  logic [SLOT_W-1:0]  out_slot;

  // Window walk.
  logic [Y_W-1:0]    ry;
  logic [Y_W-1:0]    ry_end;
  logic [SLOT_W-1:0] rslot;
  logic [COL_W-1:0]  rx;
  logic [COL_W-1:0]  rx0;
  logic [COL_W-1:0]  rx_end;
  logic              rd_v;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  cnt;
  logic              last_r;

  logic [PIXEL_W-1:0] line_store [MEM_DEPTH];
  logic [PIXEL_W-1:0] rdata;
  logic [MADDR_W-1:0] waddr;
  logic [MADDR_W-1:0] raddr;

  logic               accept;
  logic               restart;
  logic [COL_W-1:0]   ic;
  logic [INROW_W-1:0] ir;
  logic [SLOT_W-1:0]  islot;
  logic [COL_W-1:0]   oc;
  logic [ROW_W-1:0]   orow;
  logic [SLOT_W-1:0]  oslot;
  logic               do_store;
  logic               emit;
  logic               in_wrap;
  logic [Y_W-1:0]     y0;
  logic [Y_W-1:0]     y1;
  logic [Y_W-1:0]     y_hi;
  logic [ER_W-1:0]    dy;
  logic [SLOT_W-1:0]  slot0;
  logic [COL_W-1:0]   x0;
  logic [X_W-1:0]     x_hi;
  logic [X_W-1:0]     x1;
  logic               no_cols;
  logic               out_col_wrap;
  logic               last;

  logic               div_done;
  logic [PIXEL_W-1:0] div_quot;

  assign in_stall = rst || (state != S_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    restart = 32'(out_row) >= 32'(eh);
    ic    = restart ? '0 : in_column;
    ir    = restart ? '0 : in_row;
    islot = restart ? '0 : in_slot;
    oc    = restart ? '0 : out_column;
    orow  = restart ? '0 : out_row;
    oslot = restart ? '0 : out_slot;

    do_store = (mode == MODE_PIXEL) && (32'(ir) < 32'(eh));
    in_wrap  = 32'(ic) + 32'd1 >= 32'(ew);
    emit = (do_store && (Y_W'(orow) + Y_W'(er) + Y_W'(1) <= Y_W'(ir))) ||
           ((mode == MODE_FLUSH) && (32'(ir) >= 32'(eh)));

    y0    = (32'(orow) >= 32'(er)) ? Y_W'(orow) - Y_W'(er) : '0;
    dy    = ER_W'(Y_W'(orow) - y0);
    slot0 = (32'(oslot) >= 32'(dy)) ? oslot - SLOT_W'(dy)
                                    : SLOT_W'(32'(oslot) + LINE_ROWS - 32'(dy));
    y_hi  = Y_W'(orow) + Y_W'(er);
    y1    = (32'(y_hi) >= 32'(eh)) ? Y_W'(eh) - Y_W'(1) : y_hi;
    x0    = (32'(oc) >= 32'(er)) ? oc - COL_W'(er) : '0;
    x_hi  = X_W'(oc) + X_W'(er);
    x1    = (32'(x_hi) >= 32'(ew)) ? X_W'(ew) - X_W'(1) : x_hi;
    no_cols      = 32'(oc) >= 32'(ew);
    out_col_wrap = 32'(oc) + 32'd1 >= 32'(ew);
    last         = (32'(orow) + 32'd1 >= 32'(eh)) && out_col_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_column  <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      out_column <= '0;
      out_row    <= '0;
      out_slot   <= '0;
      rd_v       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_v <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            in_column  <= ic;
            in_row     <= ir;
            in_slot    <= islot;
            out_column <= oc;
            out_row    <= orow;
            out_slot   <= oslot;
            if (do_store) begin
              if (in_wrap) begin
                in_column <= '0;
                in_row    <= ir + 1'b1;
                in_slot   <= (32'(islot) == LINE_ROWS - 1) ? '0 : islot + 1'b1;
              end else begin
                in_column <= ic + 1'b1;
              end
            end
            if (emit) begin
              ry     <= y0;
              ry_end <= y1;
              rslot  <= slot0;
              rx     <= x0;
              rx0    <= x0;
              rx_end <= COL_W'(x1);
              sum    <= '0;
              cnt    <= '0;
              last_r <= last;
              state  <= no_cols ? S_START : S_SUM;
              if (last) begin
                in_column  <= '0;
                in_row     <= '0;
                in_slot    <= '0;
                out_column <= '0;
                out_row    <= '0;
                out_slot   <= '0;
              end else if (out_col_wrap) begin
                out_column <= '0;
                out_row    <= orow + 1'b1;
                out_slot   <= (32'(oslot) == LINE_ROWS - 1) ? '0 : oslot + 1'b1;
              end else begin
                out_column <= oc + 1'b1;
              end
            end
          end
        end
        S_SUM: begin
          rd_v <= 1'b1;
          if (rx == rx_end) begin
            rx <= rx0;
            if (ry == ry_end) begin
              state <= S_DRAIN;
            end else begin
              ry    <= ry + 1'b1;
              rslot <= (32'(rslot) == LINE_ROWS - 1) ? '0 : rslot + 1'b1;
            end
          end else begin
            rx <= rx + 1'b1;
          end
        end
        S_DRAIN: state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            out_valid  <= 1'b1;
            blurred    <= div_quot;
            frame_last <= last_r;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Read data arrives in the cycle after its address was issued.
      if (rd_v) begin
        sum <= sum + SUM_W'(rdata);
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign waddr = MADDR_W'(32'(islot) * MAX_WIDTH + 32'(ic));
  assign raddr = MADDR_W'(32'(rslot) * MAX_WIDTH + 32'(rx));

  always_ff @(posedge clk) begin
    if (accept && do_store) line_store[waddr] <= pixel;
  end

  always_ff @(posedge clk) begin
    rdata <= line_store[raddr];
  end

  bbwm_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_START),
    .num  (sum),
    .den  (cnt),
    .done (div_done),
    .quot (div_quot)
  );

endmodule

[design/bbwm_div.sv]
// ----------------------------------------------------------------------------
// Box blur window mean: sequential divider
// Restoring divider, one quotient bit per cycle, returns the low 8 bits.
// ----------------------------------------------------------------------------
module bbwm_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [NUM_W-1:0]             num,
  input  logic [DEN_W-1:0]             den,
  output logic                         done,
  output logic [bbwm_pkg::PIXEL_W-1:0] quot
);
  import bbwm_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  q;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]    rem_shift;
  logic              fits;

  assign rem_shift = {rem, q[NUM_W-1]};
  assign fits      = rem_shift >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_W'(NUM_W);
        rem   <= '0;
        q     <= num;
        den_r <= den;
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        rem   <= fits ? DEN_W'(rem_shift - {1'b0, den_r}) : DEN_W'(rem_shift);
        q     <= {q[NUM_W-2:0], fits};
        done  <= (steps == STEP_W'(1));
      end
    end
  end

  // An empty window (column beyond a lowered width) averages to zero.
  assign quot = (den_r == '0) ? '0 : q[PIXEL_W-1:0];

endmodule
